// File: src/mersenne_twister_generator_assert.svh
// assertion macros for the mersenne twister generator checker
// no dependencies; included by the checker file
`ifndef MERSENNE_TWISTER_GENERATOR_ASSERT_SVH
`define MERSENNE_TWISTER_GENERATOR_ASSERT_SVH

// clocked assertion, off while reset is high
`define MTG_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define MTG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/mtg_pkg.sv
// shared types, constants and functions of the mersenne twister generator
// no dependencies
package mtg_pkg;

  localparam int TableDepth  = 624;
  localparam int TwistOffset = 397;

  localparam int WordW = 32;
  localparam int AddrW = 3;

  localparam logic [WordW-1:0] TwistMatrix = 32'h9908b0df;
  localparam logic [WordW-1:0] SeedMult    = 32'd1812433253;
  localparam logic [WordW-1:0] TemperB     = 32'h9d2c5680;
  localparam logic [WordW-1:0] TemperC     = 32'hefc60000;
  localparam logic [WordW-1:0] SeedReset   = 32'd5489;

  typedef enum logic {
    REG_SEED  = 1'b0,
    REG_NONE  = 1'b1
  } reg_idx_t;

  typedef enum logic {
    SEED_FILL,
    SEED_DONE
  } seed_state_t;

  typedef struct packed {
    logic busy;
    logic wr;
    logic first;
  } seed_ctl_t;

  function automatic logic [WordW-1:0] temper(input logic [WordW-1:0] x);
    logic [WordW-1:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: src/mtg_table.sv
// state table memory: one write port, two registered read ports
// depends on mtg_pkg
module mtg_table #(
  parameter int TABLE_DEPTH = mtg_pkg::TableDepth,
  localparam int IdxW = $clog2(TABLE_DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [IdxW-1:0]          waddr,
  input  logic [mtg_pkg::WordW-1:0] wdata,
  input  logic [IdxW-1:0]          raddr_a,
  output logic [mtg_pkg::WordW-1:0] rdata_a,
  input  logic [IdxW-1:0]          raddr_b,
  output logic [mtg_pkg::WordW-1:0] rdata_b
);

  logic [mtg_pkg::WordW-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: src/mtg_seeder.sv
// seeding sequencer: fills the table from the seed, one entry per cycle
// depends on mtg_pkg
module mtg_seeder #(
  parameter int TABLE_DEPTH = mtg_pkg::TableDepth,
  localparam int IdxW = $clog2(TABLE_DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic [mtg_pkg::WordW-1:0] seed,
  output mtg_pkg::seed_ctl_t        ctl,
  output logic [IdxW-1:0]           wr_addr,
  output logic [mtg_pkg::WordW-1:0] wr_data
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  mtg_pkg::seed_state_t state, state_next;
  logic [IdxW-1:0]           cnt;
  logic [mtg_pkg::WordW-1:0] prev;
  logic [mtg_pkg::WordW-1:0] mixed;
  logic [mtg_pkg::WordW-1:0] prod;

  assign mixed   = prev ^ (prev >> 30);
  assign prod    = mtg_pkg::WordW'(mixed * mtg_pkg::SeedMult);
  assign wr_addr = cnt;
  assign wr_data = ctl.first ? seed : prod + mtg_pkg::WordW'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtg_pkg::SEED_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      cnt <= '0;
    end else if (ctl.wr) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      prev <= wr_data;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      mtg_pkg::SEED_FILL: begin
        ctl.busy  = 1'b1;
        ctl.wr    = 1'b1;
        ctl.first = (cnt == '0);
        if (cnt == LastIdx) begin
          state_next = mtg_pkg::SEED_DONE;
        end
      end
      mtg_pkg::SEED_DONE: begin
        state_next = mtg_pkg::SEED_DONE;
      end
    endcase
    if (restart) begin
      state_next = mtg_pkg::SEED_FILL;
    end
  end

endmodule

// File: src/mersenne_twister_generator.sv
// MT19937 generator top level: config port, per-word twist, tempering, output register
// depends on mtg_pkg, mtg_table and mtg_seeder
// Each accepted transfer with draw_request set returns one tempered 32-bit word; the block
// takes one request per cycle while in_stall is low, rebuilding one table entry per request
// from a two-read, one-write memory, with the current entry held in a register from the
// previous read. After reset and after every seed write the table is refilled, one seeding
// multiply per entry, and in_stall stays high during that time.
module mersenne_twister_generator #(
  parameter int TABLE_DEPTH  = mtg_pkg::TableDepth,
  parameter int TWIST_OFFSET = mtg_pkg::TwistOffset
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        draw_request,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mtg_pkg::WordW-1:0]   random_word,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtg_pkg::AddrW-1:0]   paddr,
  input  logic [mtg_pkg::WordW-1:0]   pwdata,
  output logic [mtg_pkg::WordW-1:0]   prdata,
  output logic                        pready
);

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);
  localparam logic [IdxW-1:0] FarInit = IdxW'(TWIST_OFFSET);

  logic [mtg_pkg::WordW-1:0] seed;
  mtg_pkg::reg_idx_t         reg_idx;
  logic                      seed_wr;

  mtg_pkg::seed_ctl_t        sctl;
  logic [IdxW-1:0]           seed_addr;
  logic [mtg_pkg::WordW-1:0] seed_data;

  logic [IdxW-1:0]           pos, pos_next;
  logic [IdxW-1:0]           nxt_pos, nxt_pos_next;
  logic [IdxW-1:0]           far_pos, far_pos_next;
  logic [mtg_pkg::WordW-1:0] cur_word;
  logic [mtg_pkg::WordW-1:0] rd_nxt, rd_far;
  logic [mtg_pkg::WordW-1:0] y, w;

  logic                      step;
  logic                      mem_we;
  logic [IdxW-1:0]           mem_waddr;
  logic [mtg_pkg::WordW-1:0] mem_wdata;

  // config port
  assign pready  = 1'b1;
  assign reg_idx = mtg_pkg::reg_idx_t'(paddr[2]);
  assign seed_wr = psel && penable && pwrite && (reg_idx == mtg_pkg::REG_SEED);

  always_comb begin
    unique case (reg_idx)
      mtg_pkg::REG_SEED: prdata = seed;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= mtg_pkg::SeedReset;
    end else if (seed_wr) begin
      seed <= pwdata;
    end
  end

  mtg_seeder #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seeder (
    .clk     (clk),
    .rst     (rst),
    .restart (seed_wr),
    .seed    (seed),
    .ctl     (sctl),
    .wr_addr (seed_addr),
    .wr_data (seed_data)
  );

  // handshake
  assign in_stall = sctl.busy || (out_valid && out_stall);
  assign step     = in_valid && !in_stall && draw_request;

  // twist of one entry
  assign y = {cur_word[mtg_pkg::WordW-1], rd_nxt[mtg_pkg::WordW-2:0]};
  assign w = rd_far ^ (y >> 1) ^ (y[0] ? mtg_pkg::TwistMatrix : '0);

  // position counters, read addresses come from the next values
  always_comb begin
    pos_next     = pos;
    nxt_pos_next = nxt_pos;
    far_pos_next = far_pos;
    if (sctl.busy) begin
      pos_next     = '0;
      nxt_pos_next = IdxW'(1);
      far_pos_next = FarInit;
    end else if (step) begin
      pos_next     = nxt_pos;
      nxt_pos_next = (nxt_pos == LastIdx) ? '0 : nxt_pos + 1'b1;
      far_pos_next = (far_pos == LastIdx) ? '0 : far_pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      nxt_pos <= IdxW'(1);
      far_pos <= FarInit;
    end else begin
      pos     <= pos_next;
      nxt_pos <= nxt_pos_next;
      far_pos <= far_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (sctl.first) begin
      cur_word <= seed_data;
    end else if (step) begin
      cur_word <= rd_nxt;
    end
  end

  assign mem_we    = sctl.wr || step;
  assign mem_waddr = sctl.busy ? seed_addr : pos;
  assign mem_wdata = sctl.busy ? seed_data : w;

  mtg_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (nxt_pos_next),
    .rdata_a (rd_nxt),
    .raddr_b (far_pos_next),
    .rdata_b (rd_far)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      random_word <= mtg_pkg::temper(w);
    end
  end

endmodule

// File: src/mtg_checker.sv
// port-level checker for the mersenne twister generator, bound to the top level
// depends on mersenne_twister_generator_assert.svh and mtg_pkg
`include "mersenne_twister_generator_assert.svh"

module mtg_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        draw_request,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [mtg_pkg::WordW-1:0]   random_word,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [mtg_pkg::AddrW-1:0]   paddr
);

  // held result transfer keeps its word
  `MTG_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(random_word), "stalled result changed")

  // table refill follows reset
  `MTG_ASSERT_ALWAYS(a_busy_after_rst, clk, rst |=> in_stall, "not busy after reset")

  // a seed write starts a refill
  `MTG_ASSERT(a_busy_after_seed, clk, rst, psel && penable && pwrite && !paddr[2] |=> in_stall, "not busy after seed write")

  // accepted draw gives a result next cycle
  `MTG_ASSERT(a_draw_result, clk, rst, in_valid && !in_stall && draw_request |=> out_valid, "draw gave no result")

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .draw_request (draw_request),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .random_word  (random_word),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr)
);

// File: tb/mersenne_twister_generator_tb.sv
// self-checking testbench for the mersenne twister generator: random-gap request driver,
// random-stall result monitor and a word-level model of the table, checked per transfer
// depends on mtg_pkg and mersenne_twister_generator
module mersenne_twister_generator_tb;

  localparam logic [mtg_pkg::AddrW-1:0] SeedAddr   = {mtg_pkg::REG_SEED, 2'b00};
  localparam logic [mtg_pkg::AddrW-1:0] UnusedAddr = {mtg_pkg::REG_NONE, 2'b00};
  localparam logic [mtg_pkg::WordW-1:0] UpperMask  = 32'h80000000;
  localparam logic [mtg_pkg::WordW-1:0] LowerMask  = 32'h7fffffff;
  localparam int LongHold   = 300;
  localparam int IdleLimit  = 4000;
  localparam int DrainGuard = 8;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      draw_request = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [mtg_pkg::WordW-1:0] random_word;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [mtg_pkg::AddrW-1:0] paddr = '0;
  logic [mtg_pkg::WordW-1:0] pwdata = '0;
  logic [mtg_pkg::WordW-1:0] prdata;
  logic                      pready;

  mersenne_twister_generator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .draw_request(draw_request),
    .out_valid(out_valid), .out_stall(out_stall), .random_word(random_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // word table model
  logic [mtg_pkg::WordW-1:0] mt_words [mtg_pkg::TableDepth];
  int unsigned               mt_pos;
  logic [mtg_pkg::WordW-1:0] seed_reg;

  bit                        draw_queue [$];
  logic [mtg_pkg::WordW-1:0] expected_words [$];
  int                        errors = 0;
  bit                        sender_gaps_on = 1'b1;
  bit                        receiver_stalls_on = 1'b1;
  int                        holds_asked = 0;
  int                        holds_done = 0;

  function automatic void seed_words(input logic [mtg_pkg::WordW-1:0] s);
    mt_words[0] = s;
    for (int i = 1; i < mtg_pkg::TableDepth; i++) begin
      mt_words[i] = mtg_pkg::SeedMult * (mt_words[i-1] ^ (mt_words[i-1] >> 30))
                    + mtg_pkg::WordW'(i);
    end
    mt_pos = 0;
  endfunction

  function automatic logic [mtg_pkg::WordW-1:0] advance_word();
    int unsigned               nxt;
    int unsigned               far;
    logic [mtg_pkg::WordW-1:0] y;
    logic [mtg_pkg::WordW-1:0] v;
    logic [mtg_pkg::WordW-1:0] t;
    nxt = (mt_pos + 1 == mtg_pkg::TableDepth) ? 0 : mt_pos + 1;
    far = mt_pos + mtg_pkg::TwistOffset;
    if (far >= mtg_pkg::TableDepth) far = far - mtg_pkg::TableDepth;
    y = (mt_words[mt_pos] & UpperMask) | (mt_words[nxt] & LowerMask);
    v = mt_words[far] ^ (y >> 1) ^ (y[0] ? mtg_pkg::TwistMatrix : '0);
    mt_words[mt_pos] = v;
    mt_pos = nxt;
    t = v ^ (v >> 11);
    t = t ^ ((t << 7) & mtg_pkg::TemperB);
    t = t ^ ((t << 15) & mtg_pkg::TemperC);
    t = t ^ (t >> 18);
    return t;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  // request driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall && draw_request) expected_words.push_back(advance_word());
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (draw_queue.size() > 0) begin
          in_valid <= 1'b1;
          draw_request <= draw_queue.pop_front();
          send_gap = sender_gaps_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int stall_left = 0;
  logic [mtg_pkg::WordW-1:0] want;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, random_word %h", $time, random_word);
        end else begin
          want = expected_words.pop_front();
          if (random_word !== want) begin
            errors++;
            $display("%0t: random_word mismatch, expected %h actual %h",
                     $time, want, random_word);
          end
        end
      end
      if (holds_done != holds_asked && out_valid) begin
        holds_done++;
        stall_left = LongHold;
      end else if (stall_left == 0 && receiver_stalls_on) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("mersenne_twister_generator regression: fail");
        $finish;
      end
    end
  end

  task automatic queue_draws(input int count, input int zero_pct);
    for (int i = 0; i < count; i++) begin
      draw_queue.push_back($urandom_range(0, 99) >= zero_pct);
    end
  endtask

  task automatic wait_drained();
    while (draw_queue.size() != 0 || in_valid || expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainGuard) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mtg_pkg::AddrW-1:0] addr,
                           input logic [mtg_pkg::WordW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == SeedAddr) begin
      seed_reg = data;
      seed_words(data);
    end
  endtask

  task automatic read_reg(input logic [mtg_pkg::AddrW-1:0] addr,
                          input logic [mtg_pkg::WordW-1:0] want_val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want_val) begin
      errors++;
      $display("%0t: prdata mismatch, expected %h actual %h", $time, want_val, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    seed_reg = mtg_pkg::SeedReset;
    seed_words(mtg_pkg::SeedReset);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // default seed: directed mix with idle items and a long result hold, then random draws
    read_reg(SeedAddr, mtg_pkg::SeedReset);
    for (int i = 0; i < 20; i++) begin
      draw_queue.push_back(i % 4 != 3 || i == 19);
    end
    holds_asked++;
    queue_draws(40, 0);
    queue_draws(650, 10);
    wait_drained();

    // seed zero, plus a write to an unused register
    write_reg(SeedAddr, '0);
    write_reg(UnusedAddr, 32'h12345678);
    read_reg(SeedAddr, '0);
    queue_draws(60, 10);
    wait_drained();

    write_reg(SeedAddr, '1);
    read_reg(SeedAddr, '1);
    queue_draws(60, 10);
    wait_drained();

    // random seed at full rate
    sender_gaps_on = 1'b0;
    receiver_stalls_on = 1'b0;
    write_reg(SeedAddr, $urandom());
    read_reg(SeedAddr, seed_reg);
    queue_draws(60, 5);
    wait_drained();

    if (errors == 0 && expected_words.size() == 0) begin
      $display("mersenne_twister_generator regression: pass");
    end else begin
      $display("mersenne_twister_generator regression: fail");
    end
    $finish;
  end

endmodule
